>>> sv/esl_pkg.sv
// Package for the escape sequence lexer: token kinds, character constants,
// the token record and the character class functions.
// No dependencies.
package esl_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned PosW   = 16;
  localparam int unsigned KindW  = 4;
  localparam int unsigned TextW  = 32;
  localparam int unsigned LenW   = 3;
  localparam int unsigned CountW = 3;

  // Token kinds as carried in token_kind.
  localparam logic [KindW-1:0] KIND_LITERAL = 4'd0;
  localparam logic [KindW-1:0] KIND_SQUOTE  = 4'd1;
  localparam logic [KindW-1:0] KIND_DQUOTE  = 4'd2;
  localparam logic [KindW-1:0] KIND_BSLASH  = 4'd3;
  localparam logic [KindW-1:0] KIND_NL      = 4'd4;
  localparam logic [KindW-1:0] KIND_CR      = 4'd5;
  localparam logic [KindW-1:0] KIND_TAB     = 4'd6;
  localparam logic [KindW-1:0] KIND_BS      = 4'd7;
  localparam logic [KindW-1:0] KIND_FF      = 4'd8;
  localparam logic [KindW-1:0] KIND_BELL    = 4'd9;
  localparam logic [KindW-1:0] KIND_DOLLAR  = 4'd10;
  localparam logic [KindW-1:0] KIND_OCTAL   = 4'd11;
  localparam logic [KindW-1:0] KIND_HEX     = 4'd12;
  localparam logic [KindW-1:0] KIND_UNICODE = 4'd13;
  localparam logic [KindW-1:0] KIND_ERROR   = 4'd14;
  localparam logic [KindW-1:0] KIND_NONE    = 4'd0;

  localparam logic [CharW-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CharW-1:0] CH_SQUOTE = 8'h27;
  localparam logic [CharW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [CharW-1:0] CH_N      = 8'h6E;
  localparam logic [CharW-1:0] CH_R      = 8'h72;
  localparam logic [CharW-1:0] CH_T      = 8'h74;
  localparam logic [CharW-1:0] CH_B      = 8'h62;
  localparam logic [CharW-1:0] CH_F      = 8'h66;
  localparam logic [CharW-1:0] CH_A      = 8'h61;
  localparam logic [CharW-1:0] CH_DOLLAR = 8'h24;
  localparam logic [CharW-1:0] CH_ZERO   = 8'h30;
  localparam logic [CharW-1:0] CH_SEVEN  = 8'h37;
  localparam logic [CharW-1:0] CH_NINE   = 8'h39;
  localparam logic [CharW-1:0] CH_X      = 8'h78;
  localparam logic [CharW-1:0] CH_U      = 8'h75;
  localparam logic [CharW-1:0] CH_LC_A   = 8'h61;
  localparam logic [CharW-1:0] CH_LC_F   = 8'h66;
  localparam logic [CharW-1:0] CH_UC_A   = 8'h41;
  localparam logic [CharW-1:0] CH_UC_F   = 8'h46;

  localparam logic [LenW-1:0] LEN_NONE  = 3'd0;
  localparam logic [LenW-1:0] LEN_ONE   = 3'd1;
  localparam logic [LenW-1:0] LEN_SHORT = 3'd2;
  localparam logic [LenW-1:0] LEN_LONG  = 3'd4;

  typedef struct packed {
    logic [LenW-1:0]  text_length;
    logic [TextW-1:0] text_chars;
    logic [PosW-1:0]  token_column;
    logic [PosW-1:0]  token_line;
    logic [KindW-1:0] token_kind;
  } token_t;

  localparam int unsigned TokenW    = $bits(token_t);
  localparam int unsigned OutDataW  = ((TokenW + 7) / 8) * 8;
  localparam int unsigned InFieldsW = CharW + 2 * PosW;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;

  // Returns the simple escape kind for a character, or KIND_NONE.
  function automatic logic [KindW-1:0] simple_kind(input logic [CharW-1:0] c);
    logic [KindW-1:0] k;
    case (c)
      CH_SQUOTE: k = KIND_SQUOTE;
      CH_DQUOTE: k = KIND_DQUOTE;
      CH_BSLASH: k = KIND_BSLASH;
      CH_N:      k = KIND_NL;
      CH_R:      k = KIND_CR;
      CH_T:      k = KIND_TAB;
      CH_B:      k = KIND_BS;
      CH_F:      k = KIND_FF;
      CH_A:      k = KIND_BELL;
      CH_DOLLAR: k = KIND_DOLLAR;
      default:   k = KIND_NONE;
    endcase
    return k;
  endfunction

  function automatic logic is_octal(input logic [CharW-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_SEVEN);
  endfunction

  function automatic logic is_hex(input logic [CharW-1:0] c);
    return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
           ((c >= CH_LC_A) && (c <= CH_LC_F)) ||
           ((c >= CH_UC_A) && (c <= CH_UC_F));
  endfunction

endpackage

>>> sv/escape_sequence_lexer.sv
// Top level of the escape sequence lexer.
// Instantiates esl_lexer and esl_out_buf; depends on esl_pkg.
//
// Usage:
//   Input stream (in_*): one source character per beat with its line and
//   column. Output stream (out_*): one token per beat, or none for a beat
//   that opens or continues an escape or is an unknown escape letter.
//   A plain character gives a literal token; a backslash followed by a
//   simple escape letter gives that escape token; \0, \x and \u collect
//   two, two or four raw characters and give an octal, hex, unicode or
//   error token positioned at the backslash.
// Output: the token that a beat completes is written into the result buffer
//   when that beat is accepted, and out_tvalid shows the output register.
// Throughput: one character per cycle, sustained, as long as the receiver
//   takes tokens; the lexer next state is combinational logic on its registers.
// Reset: rst_n low for one clock returns the lexer to idle and empties the
//   result buffer; in_tready is high right after reset.
// Stall: a result register and a skid register hold up to two tokens; when
//   both are full in_tready drops until the receiver takes a token. A
//   partly collected escape waits indefinitely for its remaining characters.
module escape_sequence_lexer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [7:0] char_code, [23:8] line_number, [39:24] column_number
  input  logic [esl_pkg::InDataW-1:0]   in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [3:0] token_kind, [19:4] token_line, [35:20] token_column,
  // [67:36] text_chars, [70:68] text_length, [71] zero
  output logic [esl_pkg::OutDataW-1:0]  out_tdata
);

  logic            in_accept;
  logic            can_push;
  logic            tok_valid;
  esl_pkg::token_t tok;
  esl_pkg::token_t out_tok;

  assign in_tready = can_push;
  assign in_accept = in_tvalid & can_push;

  esl_lexer u_lexer (
    .clk           (clk),
    .rst_n         (rst_n),
    .char_accept   (in_accept),
    .char_code     (in_tdata[esl_pkg::CharW-1:0]),
    .line_number   (in_tdata[esl_pkg::CharW +: esl_pkg::PosW]),
    .column_number (in_tdata[esl_pkg::CharW + esl_pkg::PosW +: esl_pkg::PosW]),
    .tok_valid     (tok_valid),
    .tok           (tok)
  );

  esl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept & tok_valid),
    .push_tok  (tok),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_tok   (out_tok)
  );

  assign out_tdata = {{(esl_pkg::OutDataW - esl_pkg::TokenW){1'b0}}, out_tok};

endmodule

>>> sv/esl_lexer.sv
// Lexer state machine: holds the escape state and builds at most one token
// per accepted character. Depends on esl_pkg.
module esl_lexer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                char_accept,
  input  logic [esl_pkg::CharW-1:0] char_code,
  input  logic [esl_pkg::PosW-1:0]  line_number,
  input  logic [esl_pkg::PosW-1:0]  column_number,
  output logic                tok_valid,
  output esl_pkg::token_t     tok
);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_DIGITS = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    DK_OCTAL   = 2'd0,
    DK_HEX     = 2'd1,
    DK_UNICODE = 2'd2
  } digit_kind_t;

  mode_t                           mode_r, mode_nxt;
  digit_kind_t                     dkind_r, dkind_nxt;
  logic [esl_pkg::CountW-1:0]      seen_r, seen_nxt;
  logic [esl_pkg::TextW-1:0]       buf_r, buf_nxt;
  logic                            dvalid_r, dvalid_nxt;
  logic [esl_pkg::PosW-1:0]        sline_r, sline_nxt;
  logic [esl_pkg::PosW-1:0]        scol_r, scol_nxt;

  logic [esl_pkg::KindW-1:0]       skind;
  logic [esl_pkg::CountW-1:0]      seen_inc;
  logic [esl_pkg::LenW-1:0]        need;
  logic                            digit_ok;
  logic [esl_pkg::TextW-1:0]       buf_ins;

  always_comb begin
    skind    = esl_pkg::simple_kind(char_code);
    seen_inc = seen_r + 3'd1;
    need     = (dkind_r == DK_OCTAL || dkind_r == DK_HEX) ? esl_pkg::LEN_SHORT
                                                          : esl_pkg::LEN_LONG;
    digit_ok = (dkind_r == DK_OCTAL) ? esl_pkg::is_octal(char_code)
                                     : esl_pkg::is_hex(char_code);
    // The new raw character lands in the byte lane given by the count.
    buf_ins  = buf_r | ({24'd0, char_code} << {seen_r[1:0], 3'b000});

    mode_nxt   = mode_r;
    dkind_nxt  = dkind_r;
    seen_nxt   = seen_r;
    buf_nxt    = buf_r;
    dvalid_nxt = dvalid_r;
    sline_nxt  = sline_r;
    scol_nxt   = scol_r;

    tok_valid        = 1'b0;
    tok.token_kind   = esl_pkg::KIND_LITERAL;
    tok.token_line   = line_number;
    tok.token_column = column_number;
    tok.text_chars   = {24'd0, char_code};
    tok.text_length  = esl_pkg::LEN_ONE;

    unique case (mode_r)
      MODE_ESCAPE: begin
        tok.token_line   = sline_r;
        tok.token_column = scol_r;
        tok.text_chars   = '0;
        tok.text_length  = esl_pkg::LEN_NONE;
        tok.token_kind   = skind;
        seen_nxt   = '0;
        buf_nxt    = '0;
        dvalid_nxt = 1'b1;
        if (skind != esl_pkg::KIND_NONE) begin
          tok_valid = 1'b1;
          mode_nxt  = MODE_IDLE;
          dkind_nxt = DK_OCTAL;
        end else if (char_code == esl_pkg::CH_ZERO) begin
          mode_nxt  = MODE_DIGITS;
          dkind_nxt = DK_OCTAL;
        end else if (char_code == esl_pkg::CH_X) begin
          mode_nxt  = MODE_DIGITS;
          dkind_nxt = DK_HEX;
        end else if (char_code == esl_pkg::CH_U) begin
          mode_nxt  = MODE_DIGITS;
          dkind_nxt = DK_UNICODE;
        end else begin
          // Unknown escape letter: drop it silently.
          mode_nxt  = MODE_IDLE;
          dkind_nxt = DK_OCTAL;
        end
      end
      MODE_DIGITS: begin
        tok.token_line   = sline_r;
        tok.token_column = scol_r;
        tok.text_chars   = buf_ins;
        tok.text_length  = need;
        if (!dvalid_r || !digit_ok) begin
          tok.token_kind = esl_pkg::KIND_ERROR;
        end else if (dkind_r == DK_OCTAL) begin
          tok.token_kind = esl_pkg::KIND_OCTAL;
        end else if (dkind_r == DK_HEX) begin
          tok.token_kind = esl_pkg::KIND_HEX;
        end else begin
          tok.token_kind = esl_pkg::KIND_UNICODE;
        end
        if (seen_inc >= need) begin
          tok_valid  = 1'b1;
          mode_nxt   = MODE_IDLE;
          dkind_nxt  = DK_OCTAL;
          seen_nxt   = '0;
          buf_nxt    = '0;
          dvalid_nxt = 1'b1;
        end else begin
          seen_nxt   = seen_inc;
          buf_nxt    = buf_ins;
          dvalid_nxt = dvalid_r & digit_ok;
        end
      end
      default: begin
        dkind_nxt  = DK_OCTAL;
        seen_nxt   = '0;
        buf_nxt    = '0;
        dvalid_nxt = 1'b1;
        if (char_code == esl_pkg::CH_BSLASH) begin
          mode_nxt  = MODE_ESCAPE;
          sline_nxt = line_number;
          scol_nxt  = column_number;
        end else begin
          mode_nxt  = MODE_IDLE;
          tok_valid = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      dkind_r  <= DK_OCTAL;
      seen_r   <= '0;
      buf_r    <= '0;
      dvalid_r <= 1'b1;
      sline_r  <= '0;
      scol_r   <= '0;
    end else if (char_accept) begin
      mode_r   <= mode_nxt;
      dkind_r  <= dkind_nxt;
      seen_r   <= seen_nxt;
      buf_r    <= buf_nxt;
      dvalid_r <= dvalid_nxt;
      sline_r  <= sline_nxt;
      scol_r   <= scol_nxt;
    end
  end

endmodule

>>> sv/esl_out_buf.sv
// Two-entry result buffer: an output register plus a skid register, so the
// input side can still push one more token after the receiver stalls.
// Depends on esl_pkg.
module esl_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  esl_pkg::token_t push_tok,
  output logic            can_push,
  output logic            out_valid,
  input  logic            out_ready,
  output esl_pkg::token_t out_tok
);

  logic            main_valid_r;
  logic            skid_valid_r;
  esl_pkg::token_t main_r;
  esl_pkg::token_t skid_r;
  logic            pop;

  assign pop       = main_valid_r & out_ready;
  assign can_push  = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_tok   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_r <= push_tok;
      end else begin
        skid_r <= push_tok;
      end
    end
  end

endmodule

>>> sv/esl_checker.sv
// Port-level checker for escape_sequence_lexer, attached by bind.
// Depends on esl_pkg.
module esl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [esl_pkg::OutDataW-1:0]  out_tdata
);

  logic [esl_pkg::KindW-1:0] kind;
  logic [esl_pkg::LenW-1:0]  len;

  assign kind = out_tdata[esl_pkg::KindW-1:0];
  assign len  = out_tdata[esl_pkg::TokenW-1 -: esl_pkg::LenW];

  // A held token stays up until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  // Reset empties the result buffer.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("token shown right after reset");

  // Kind and length agree: literals carry one byte, simple escapes none,
  // digit tokens two or four.
  a_kind_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (kind == esl_pkg::KIND_LITERAL && len == esl_pkg::LEN_ONE) ||
      (kind >= esl_pkg::KIND_SQUOTE && kind <= esl_pkg::KIND_DOLLAR &&
       len == esl_pkg::LEN_NONE) ||
      ((kind == esl_pkg::KIND_OCTAL || kind == esl_pkg::KIND_HEX) &&
       len == esl_pkg::LEN_SHORT) ||
      (kind == esl_pkg::KIND_UNICODE && len == esl_pkg::LEN_LONG) ||
      (kind == esl_pkg::KIND_ERROR &&
       (len == esl_pkg::LEN_SHORT || len == esl_pkg::LEN_LONG)))
    else $error("token kind and text length disagree");

  // With both buffer entries free after a drained token, input is taken.
  a_ready_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty result buffer");

endmodule

bind escape_sequence_lexer esl_checker u_esl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> verif/tb_top.sv
// Testbench for escape_sequence_lexer: a queue-fed stream driver, a token monitor
// and a cycle-free predictor of the lexer state machine. Depends on esl_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic [1:0] {LEX_IDLE, LEX_ESCAPE, LEX_DIGITS} lex_mode_t;
  typedef enum logic [1:0] {RUN_OCTAL, RUN_HEX, RUN_UNICODE} digit_run_t;

  localparam int unsigned CharW    = esl_pkg::CharW;
  localparam int unsigned PosW     = esl_pkg::PosW;
  localparam int unsigned KindW    = esl_pkg::KindW;
  localparam int unsigned TextW    = esl_pkg::TextW;
  localparam int unsigned LenW     = esl_pkg::LenW;
  localparam int unsigned TokenW   = esl_pkg::TokenW;
  localparam int unsigned InDataW  = esl_pkg::InDataW;
  localparam int unsigned OutDataW = esl_pkg::OutDataW;

  typedef struct {
    logic [CharW-1:0] ch;
    logic [PosW-1:0]  line;
    logic [PosW-1:0]  col;
  } char_beat_t;

  localparam int unsigned RandomChars = 1150;
  localparam int unsigned CalmTail    = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  char_beat_t        chars_pending[$];
  esl_pkg::token_t   tokens_due[$];
  char_beat_t        on_bus;
  int unsigned n_chars = 0;
  int unsigned n_taken = 0;
  int unsigned n_errors = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  logic calm = 1'b0;

  // Lexer state as the predictor sees it.
  lex_mode_t        lx_mode = LEX_IDLE;
  digit_run_t       lx_run = RUN_OCTAL;
  logic [2:0]       lx_seen = '0;
  logic [TextW-1:0] lx_buf = '0;
  logic             lx_valid = 1'b1;
  logic [PosW-1:0]  lx_line = '0;
  logic [PosW-1:0]  lx_col = '0;

  // Generator position cursor.
  logic [PosW-1:0] gen_line = '0;
  logic [PosW-1:0] gen_col = '0;

  escape_sequence_lexer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Kind of a simple escape letter, or KIND_LITERAL when the letter is not one.
  function automatic logic [KindW-1:0] escape_letter_kind(input logic [CharW-1:0] c);
    case (c)
      esl_pkg::CH_SQUOTE: return esl_pkg::KIND_SQUOTE;
      esl_pkg::CH_DQUOTE: return esl_pkg::KIND_DQUOTE;
      esl_pkg::CH_BSLASH: return esl_pkg::KIND_BSLASH;
      esl_pkg::CH_N:      return esl_pkg::KIND_NL;
      esl_pkg::CH_R:      return esl_pkg::KIND_CR;
      esl_pkg::CH_T:      return esl_pkg::KIND_TAB;
      esl_pkg::CH_B:      return esl_pkg::KIND_BS;
      esl_pkg::CH_F:      return esl_pkg::KIND_FF;
      esl_pkg::CH_A:      return esl_pkg::KIND_BELL;
      esl_pkg::CH_DOLLAR: return esl_pkg::KIND_DOLLAR;
      default:            return esl_pkg::KIND_LITERAL;
    endcase
  endfunction

  function automatic logic octal_char(input logic [CharW-1:0] c);
    return c >= esl_pkg::CH_ZERO && c <= esl_pkg::CH_SEVEN;
  endfunction

  function automatic logic hex_char(input logic [CharW-1:0] c);
    return (c >= esl_pkg::CH_ZERO && c <= esl_pkg::CH_NINE) ||
           (c >= esl_pkg::CH_LC_A && c <= esl_pkg::CH_LC_F) ||
           (c >= esl_pkg::CH_UC_A && c <= esl_pkg::CH_UC_F);
  endfunction

  function automatic esl_pkg::token_t make_token(input logic [KindW-1:0] kind,
                                                 input logic [PosW-1:0] line,
                                                 input logic [PosW-1:0] col,
                                                 input logic [TextW-1:0] text,
                                                 input logic [LenW-1:0] len);
    esl_pkg::token_t t;
    t.token_kind   = kind;
    t.token_line   = line;
    t.token_column = col;
    t.text_chars   = text;
    t.text_length  = len;
    return t;
  endfunction

  // Appends a predicted token at the tail of the expected queue.
  task automatic expect_token(input esl_pkg::token_t t);
    tokens_due = {tokens_due, t};
  endtask

  // Appends a character at the tail of the stimulus queue.
  task automatic queue_char(input char_beat_t b);
    chars_pending = {chars_pending, b};
  endtask

  task automatic lex_reset_digits();
    lx_mode  = LEX_IDLE;
    lx_run   = RUN_OCTAL;
    lx_seen  = '0;
    lx_buf   = '0;
    lx_valid = 1'b1;
  endtask

  // Advances the predicted lexer by one character and queues the token it gives.
  task automatic lex_char(input char_beat_t b);
    logic [KindW-1:0] k;
    logic [2:0]       need;
    logic             ok;
    case (lx_mode)
      LEX_ESCAPE: begin
        k = escape_letter_kind(b.ch);
        if (k != esl_pkg::KIND_LITERAL) begin
          expect_token(make_token(k, lx_line, lx_col, '0, esl_pkg::LEN_NONE));
          lex_reset_digits();
        end else if (b.ch == esl_pkg::CH_ZERO || b.ch == esl_pkg::CH_X ||
                     b.ch == esl_pkg::CH_U) begin
          lex_reset_digits();
          lx_mode = LEX_DIGITS;
          lx_run  = (b.ch == esl_pkg::CH_ZERO) ? RUN_OCTAL :
                    (b.ch == esl_pkg::CH_X) ? RUN_HEX : RUN_UNICODE;
        end else begin
          lex_reset_digits();
        end
      end
      LEX_DIGITS: begin
        need = (lx_run == RUN_UNICODE) ? 3'd4 : 3'd2;
        ok = (lx_run == RUN_OCTAL) ? octal_char(b.ch) : hex_char(b.ch);
        lx_buf = lx_buf | (TextW'(b.ch) << (8 * lx_seen[1:0]));
        if (!ok) lx_valid = 1'b0;
        lx_seen = lx_seen + 3'd1;
        if (lx_seen >= need) begin
          k = !lx_valid ? esl_pkg::KIND_ERROR :
              (lx_run == RUN_OCTAL) ? esl_pkg::KIND_OCTAL :
              (lx_run == RUN_HEX) ? esl_pkg::KIND_HEX : esl_pkg::KIND_UNICODE;
          expect_token(make_token(k, lx_line, lx_col, lx_buf, LenW'(need)));
          lex_reset_digits();
        end
      end
      default: begin
        lex_reset_digits();
        if (b.ch == esl_pkg::CH_BSLASH) begin
          lx_mode = LEX_ESCAPE;
          lx_line = b.line;
          lx_col  = b.col;
        end else begin
          expect_token(make_token(esl_pkg::KIND_LITERAL, b.line, b.col, TextW'(b.ch),
                                  esl_pkg::LEN_ONE));
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
    n_errors++;
  endtask

  // Queues one character; positions mostly step along a line, sometimes jump.
  task automatic put_char(input logic [CharW-1:0] c);
    char_beat_t b;
    int unsigned r;
    r = $urandom_range(0, 31);
    if (r == 0) begin
      gen_line = PosW'($urandom());
      gen_col  = PosW'($urandom());
    end else if (r == 1) begin
      gen_line = $urandom_range(0, 1) ? '1 : '0;
      gen_col  = $urandom_range(0, 1) ? '1 : '0;
    end else if (r < 4) begin
      gen_line = gen_line + 1'b1;
      gen_col  = '0;
    end else begin
      gen_col = gen_col + 1'b1;
    end
    b.ch = c;
    b.line = gen_line;
    b.col = gen_col;
    queue_char(b);
  endtask

  task automatic put_at(input logic [CharW-1:0] c, input logic [PosW-1:0] line,
                        input logic [PosW-1:0] col);
    char_beat_t b;
    b.ch = c;
    b.line = line;
    b.col = col;
    gen_line = line;
    gen_col = col;
    queue_char(b);
  endtask

  function automatic logic [CharW-1:0] any_hex();
    logic [CharW-1:0] c;
    case ($urandom_range(0, 2))
      0: c = esl_pkg::CH_ZERO + CharW'($urandom_range(0, 9));
      1: c = esl_pkg::CH_LC_A + CharW'($urandom_range(0, 5));
      default: c = esl_pkg::CH_UC_A + CharW'($urandom_range(0, 5));
    endcase
    return c;
  endfunction

  // A digit of the run, or now and then an arbitrary byte that may spoil it.
  function automatic logic [CharW-1:0] run_digit(input digit_run_t run);
    if ($urandom_range(0, 9) == 0) return CharW'($urandom());
    if (run == RUN_OCTAL) return esl_pkg::CH_ZERO + CharW'($urandom_range(0, 7));
    return any_hex();
  endfunction

  function automatic logic [CharW-1:0] plain_char();
    logic [CharW-1:0] c;
    do c = CharW'($urandom()); while (c == esl_pkg::CH_BSLASH);
    return c;
  endfunction

  function automatic logic [CharW-1:0] unknown_letter();
    logic [CharW-1:0] c;
    do c = CharW'($urandom());
    while (escape_letter_kind(c) != esl_pkg::KIND_LITERAL || c == esl_pkg::CH_ZERO ||
           c == esl_pkg::CH_X || c == esl_pkg::CH_U);
    return c;
  endfunction

  task automatic put_run(input logic [CharW-1:0] prefix, input digit_run_t run);
    int n;
    n = (run == RUN_UNICODE) ? 4 : 2;
    put_char(esl_pkg::CH_BSLASH);
    put_char(prefix);
    repeat (n) put_char(run_digit(run));
  endtask

  task automatic fill_stimulus();
    logic [CharW-1:0] simple_letters[10];
    int unsigned r;
    simple_letters = '{esl_pkg::CH_SQUOTE, esl_pkg::CH_DQUOTE, esl_pkg::CH_BSLASH,
                       esl_pkg::CH_N, esl_pkg::CH_R, esl_pkg::CH_T, esl_pkg::CH_B,
                       esl_pkg::CH_F, esl_pkg::CH_A, esl_pkg::CH_DOLLAR};
    // Literals at the byte and position extremes.
    put_at(8'h00, '0, '0);
    put_at(8'hFF, '1, '1);
    // Every simple escape, the first one latched at the top position.
    put_at(esl_pkg::CH_BSLASH, '1, '1);
    put_at(simple_letters[0], 16'h0000, 16'h0000);
    for (int i = 1; i < 10; i++) begin
      put_char(esl_pkg::CH_BSLASH);
      put_char(simple_letters[i]);
    end
    // Octal: good digits, then 8 which is not an octal digit.
    put_char(esl_pkg::CH_BSLASH); put_char(esl_pkg::CH_ZERO);
    put_char(esl_pkg::CH_ZERO); put_char(esl_pkg::CH_SEVEN);
    put_char(esl_pkg::CH_BSLASH); put_char(esl_pkg::CH_ZERO);
    put_char(esl_pkg::CH_SEVEN); put_char(esl_pkg::CH_SEVEN + 8'd1);
    // Hex: mixed case, then a letter past f.
    put_char(esl_pkg::CH_BSLASH); put_char(esl_pkg::CH_X);
    put_char(esl_pkg::CH_LC_F); put_char(esl_pkg::CH_UC_A);
    put_char(esl_pkg::CH_BSLASH); put_char(esl_pkg::CH_X);
    put_char(esl_pkg::CH_NINE); put_char(esl_pkg::CH_LC_F + 8'd1);
    // Unicode: good, then a run holding a backslash and a high byte.
    put_char(esl_pkg::CH_BSLASH); put_char(esl_pkg::CH_U); put_char(esl_pkg::CH_ZERO);
    put_char(esl_pkg::CH_NINE); put_char(esl_pkg::CH_LC_A); put_char(esl_pkg::CH_UC_F);
    put_char(esl_pkg::CH_BSLASH); put_char(esl_pkg::CH_U); put_char(esl_pkg::CH_BSLASH);
    put_char(esl_pkg::CH_UC_A - 8'd1); put_char(8'h80); put_char(esl_pkg::CH_UC_F + 8'd1);
    // Unknown escape letter gives nothing, then a literal follows.
    put_char(esl_pkg::CH_BSLASH); put_char(8'h7A); put_char(8'h7A);

    while (chars_pending.size() < RandomChars) begin
      r = $urandom_range(0, 99);
      if (r < 35) put_char(plain_char());
      else if (r < 55) begin
        put_char(esl_pkg::CH_BSLASH);
        put_char(simple_letters[$urandom_range(0, 9)]);
      end else if (r < 65) put_run(esl_pkg::CH_ZERO, RUN_OCTAL);
      else if (r < 75) put_run(esl_pkg::CH_X, RUN_HEX);
      else if (r < 85) put_run(esl_pkg::CH_U, RUN_UNICODE);
      else if (r < 90) begin
        put_char(esl_pkg::CH_BSLASH);
        put_char(unknown_letter());
      end else begin
        put_char(CharW'($urandom()));
      end
    end
    // Close any escape the noise may have left open.
    repeat (5) put_char(plain_char());
  endtask

  // Character driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        lex_char(on_bus);
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (chars_pending.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(0, 10);
          in_tvalid <= 1'b0;
        end else begin
          on_bus = chars_pending.pop_front();
          in_tdata <= {on_bus.col, on_bus.line, on_bus.ch};
          in_tvalid <= 1'b1;
        end
      end
      calm <= (chars_pending.size() < CalmTail);
    end
  end

  // Token monitor.
  always @(posedge clk) begin
    esl_pkg::token_t got;
    esl_pkg::token_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      take_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[TokenW-1:0];
        if (tokens_due.size() == 0) begin
          note_mismatch("token with none expected, kind", got.token_kind, 0);
        end else begin
          want = tokens_due.pop_front();
          if (got.token_kind !== want.token_kind)
            note_mismatch("token_kind", got.token_kind, want.token_kind);
          if (got.token_line !== want.token_line)
            note_mismatch("token_line", got.token_line, want.token_line);
          if (got.token_column !== want.token_column)
            note_mismatch("token_column", got.token_column, want.token_column);
          if (got.text_chars !== want.text_chars)
            note_mismatch("text_chars", got.text_chars, want.text_chars);
          if (got.text_length !== want.text_length)
            note_mismatch("text_length", got.text_length, want.text_length);
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        take_gap = $urandom_range(0, 10);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    fill_stimulus();
    n_chars = chars_pending.size();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (n_taken < n_chars) @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);
    // A token arriving late or unasked for still shows up here.
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TIMEOUT waiting for the lexer");
    $display("Simulation FAILED");
    $finish;
  end

endmodule
